// ===== hw/rtl/wpd_pkg.sv =====
// Shared types and constants for the waveform peak decimator.
// Used by every module of the block; depends on nothing.
`default_nettype none

package wpd_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int LENGTH_WIDTH = 16;
  localparam int COUNT_WIDTH  = 13;
  localparam int ACC_WIDTH    = LENGTH_WIDTH + COUNT_WIDTH;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MIN   = COUNT_WIDTH'(9);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX   = COUNT_WIDTH'(4096);
  localparam logic [COUNT_WIDTH-1:0] COUNT_RESET = COUNT_WIDTH'(256);

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic [LENGTH_WIDTH-1:0]        block_length;
  } sample_item_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] point_value;
    logic                           last_point;
  } point_item_t;

  typedef struct packed {
    logic load_last;
    logic position_zero;
    logic bucket_open;
  } core_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/wpd_in_stage.sv =====
// Input register of the waveform peak decimator: holds one sample word.
// Depends on wpd_pkg for the sample word type.
`default_nettype none

module wpd_in_stage (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  sample_valid,
  output logic                       sample_stall,
  input  wire wpd_pkg::sample_item_t sample_item,
  input  wire logic                  advance,
  output logic                       held_valid,
  output wpd_pkg::sample_item_t      held_item
);

  // The held word moves on whenever the core can take it, so a new word
  // can be taken in every cycle in which the result is not stalled.
  assign sample_stall = held_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!sample_stall) begin
      held_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!sample_stall && sample_valid) begin
      held_item <= sample_item;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/wpd_bucket_core.sv =====
// Bucket tracking and peak logic with the result register.
// Depends on wpd_pkg for widths, the word types and the status struct.
`default_nettype none

module wpd_bucket_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                held_valid,
  input  wire wpd_pkg::sample_item_t               held_item,
  input  wire logic [wpd_pkg::COUNT_WIDTH-1:0]     point_count,
  output logic                                     advance,
  output logic                                     point_valid,
  input  wire logic                                point_stall,
  output wpd_pkg::point_item_t                     point_item,
  output wpd_pkg::core_status_t                    status
);

  localparam int Sw   = wpd_pkg::SAMPLE_WIDTH;
  localparam int Lw   = wpd_pkg::LENGTH_WIDTH;
  localparam int Cw   = wpd_pkg::COUNT_WIDTH;
  localparam int Aw   = wpd_pkg::ACC_WIDTH;
  localparam int NcW  = Lw + Cw;
  localparam int ProdW = Lw + 1 + Cw;

  logic [Lw-1:0]  sample_position;
  logic [Aw-1:0]  boundary_accumulator;
  logic [Sw-2:0]  running_peak;
  logic           first_sign_negative;
  logic           bucket_open;

  logic [Lw-1:0]  sample_position_next;
  logic [Aw-1:0]  boundary_accumulator_next;
  logic [Sw-2:0]  running_peak_next;
  logic           first_sign_negative_next;
  logic           bucket_open_next;

  logic [Lw-1:0]    n_eff;
  logic [Lw:0]      pos_inc;
  logic [Lw:0]      pos_plus2;
  logic             is_last;
  logic             pass_through;
  logic             s_neg;
  logic [Sw-2:0]    inv_low;
  logic [Sw-2:0]    mag;
  logic [Sw-2:0]    peak_base;
  logic [Sw-2:0]    peak_new;
  logic             sign_base;
  logic [Aw-1:0]    acc_base;
  logic [ProdW-1:0] bound;
  logic             closes;
  logic             emit;
  logic             fire;
  wpd_pkg::point_item_t result;

  assign advance = !point_valid || !point_stall;
  assign fire    = held_valid && advance;

  always_comb begin
    n_eff        = (held_item.block_length == '0) ? Lw'(1) : held_item.block_length;
    pos_inc      = {1'b0, sample_position} + (Lw+1)'(1);
    pos_plus2    = {1'b0, sample_position} + (Lw+1)'(2);
    is_last      = pos_inc >= {1'b0, n_eff};
    pass_through = NcW'(n_eff) <= NcW'(point_count);

    // Magnitude of the sample; full-scale negative saturates.
    s_neg   = held_item.sample[Sw-1];
    inv_low = ~held_item.sample[Sw-2:0];
    if (s_neg) begin
      mag = (&inv_low) ? '1 : inv_low + (Sw-1)'(1);
    end else begin
      mag = held_item.sample[Sw-2:0];
    end

    if (bucket_open) begin
      peak_base = running_peak;
      sign_base = first_sign_negative;
      acc_base  = boundary_accumulator;
    end else begin
      peak_base = '0;
      sign_base = s_neg;
      acc_base  = (sample_position == '0) ? Aw'(n_eff) : boundary_accumulator;
    end
    peak_new = (mag > peak_base) ? mag : peak_base;

    // floor(acc / T) <= p + 1 holds exactly when acc < (p + 2) * T.
    bound  = ProdW'(pos_plus2) * ProdW'(point_count);
    closes = is_last || (ProdW'(acc_base) < bound);

    sample_position_next      = sample_position;
    boundary_accumulator_next = boundary_accumulator;
    running_peak_next         = running_peak;
    first_sign_negative_next  = first_sign_negative;
    bucket_open_next          = bucket_open;
    result.last_point         = is_last;

    if (pass_through) begin
      emit                      = 1'b1;
      result.point_value        = held_item.sample;
      bucket_open_next          = 1'b0;
      boundary_accumulator_next = '0;
    end else begin
      emit                     = closes;
      running_peak_next        = peak_new;
      first_sign_negative_next = sign_base;
      if (sign_base) begin
        result.point_value = Sw'(0) - {1'b0, peak_new};
      end else begin
        result.point_value = {1'b0, peak_new};
      end
      if (closes) begin
        bucket_open_next          = 1'b0;
        boundary_accumulator_next = acc_base + Aw'(n_eff);
      end else begin
        bucket_open_next          = 1'b1;
        boundary_accumulator_next = acc_base;
      end
    end

    if (is_last) begin
      sample_position_next      = '0;
      boundary_accumulator_next = '0;
      bucket_open_next          = 1'b0;
    end else begin
      sample_position_next = pos_inc[Lw-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_position      <= '0;
      boundary_accumulator <= '0;
      running_peak         <= '0;
      first_sign_negative  <= 1'b0;
      bucket_open          <= 1'b0;
    end else if (fire) begin
      sample_position      <= sample_position_next;
      boundary_accumulator <= boundary_accumulator_next;
      running_peak         <= running_peak_next;
      first_sign_negative  <= first_sign_negative_next;
      bucket_open          <= bucket_open_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      point_valid <= 1'b0;
    end else if (advance) begin
      point_valid <= fire && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      point_item <= result;
    end
  end

  assign status.load_last     = fire && is_last;
  assign status.position_zero = sample_position == '0;
  assign status.bucket_open   = bucket_open;

endmodule

`default_nettype wire

// ===== hw/rtl/waveform_peak_decimator.sv =====
// Top level of the waveform peak decimator: configuration register, input
// register and bucket core. Depends on wpd_pkg, wpd_in_stage, wpd_bucket_core.
//
// Usage: sample words (sample, block_length) enter on sample_valid/sample_stall;
// display points (point_value, last_point) leave on point_valid/point_stall.
// A word is taken at a rising edge with valid high and stall low. Each block
// of N samples becomes point_count points, each the peak magnitude of its
// bucket with the sign of the bucket's first sample; when N <= point_count
// every sample passes through as its own point. last_point marks a block's
// final point. Most samples produce no point.
// Throughput: one sample per cycle while the receiver does not stall; the
// bucket closing test, a (position + 2) * point_count multiply and compare, is
// combinational. A closing sample goes first to the input register, its point
// then to the result register, where it stays valid until it is taken.
// point_count is written with cfg_write/cfg_data; values outside 9..4096
// are ignored. Reset (rst, synchronous) sets point_count to 256, empties both
// registers and starts a fresh block. When the receiver stalls, the result
// register holds its point, one more sample waits in the input register and
// sample_stall then rises.
`default_nettype none

module waveform_peak_decimator (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              sample_valid,
  output logic                                   sample_stall,
  input  wire wpd_pkg::sample_item_t             sample_item,
  output logic                                   point_valid,
  input  wire logic                              point_stall,
  output wpd_pkg::point_item_t                   point_item,
  input  wire logic                              cfg_write,
  input  wire logic [wpd_pkg::COUNT_WIDTH-1:0]   cfg_data
);

  logic [wpd_pkg::COUNT_WIDTH-1:0] point_count;
  logic                            advance;
  logic                            held_valid;
  wpd_pkg::sample_item_t           held_item;
  wpd_pkg::core_status_t           status;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= wpd_pkg::COUNT_RESET;
    end else if (cfg_write && cfg_data >= wpd_pkg::COUNT_MIN &&
                 cfg_data <= wpd_pkg::COUNT_MAX) begin
      point_count <= cfg_data;
    end
  end

  wpd_in_stage u_in_stage (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_item  (sample_item),
    .advance      (advance),
    .held_valid   (held_valid),
    .held_item    (held_item)
  );

  wpd_bucket_core u_core (
    .clk         (clk),
    .rst         (rst),
    .held_valid  (held_valid),
    .held_item   (held_item),
    .point_count (point_count),
    .advance     (advance),
    .point_valid (point_valid),
    .point_stall (point_stall),
    .point_item  (point_item),
    .status      (status)
  );

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    point_count >= wpd_pkg::COUNT_MIN && point_count <= wpd_pkg::COUNT_MAX)
    else $error("point_count left its legal range");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> held_valid && point_valid && point_stall)
    else $error("input stalled without a blocked result");

  a_block_end: assert property (@(posedge clk) disable iff (rst)
    status.load_last |=> status.position_zero && !status.bucket_open)
    else $error("block end did not restart the block");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    point_valid && !point_stall && !held_valid |=> !point_valid)
    else $error("result appeared with no sample pending");

endmodule

`default_nettype wire
